/* hw/rtl/rsc_pkg.sv */
// package for the resistance to switch code block: widths, constants, register indexes
`default_nettype none

package rsc_pkg;

    // field and register widths
    localparam int unsigned REQUEST_W = 23;
    localparam int unsigned VALUE_W   = 26;
    localparam int unsigned SWITCH_W  = 16;
    localparam int unsigned CODE_W    = 18;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 26;
    localparam int unsigned DIGIT_W   = 3;

    // decade count and digit limit
    localparam int unsigned NUM_DECADES = 6;
    localparam int unsigned DIGIT_MAX   = 7;

    // milliohm arithmetic: request * 1000 stays below 2**33
    localparam int unsigned REM_W  = 33;
    localparam int unsigned MULT_W = VALUE_W + DIGIT_W;
    localparam int unsigned ACC0_W = SWITCH_W + 3;

    localparam int unsigned MILLI_PER_OHM    = 1000;
    localparam int unsigned SWITCHES_IN_PATH = 6;

    // in-range window in whole ohms
    localparam int unsigned RANGE_LOW  = 10;
    localparam int unsigned RANGE_HIGH = 290000;

    // pipeline: input stage, offset stage, one stage per decade
    localparam int unsigned STAGE_LAST = NUM_DECADES + 1;
    localparam int unsigned NUM_STAGES = STAGE_LAST + 1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALUE_0, CFG_VALUE_1, CFG_VALUE_2, CFG_VALUE_3, CFG_VALUE_4, CFG_VALUE_5,
        CFG_SWITCH_ON, CFG_SPARE
    } t_cfg_reg;

    // reset values
    localparam logic [VALUE_W-1:0] VALUE_RESET [NUM_DECADES] = '{
        VALUE_W'(1200), VALUE_W'(9530), VALUE_W'(75000),
        VALUE_W'(590000), VALUE_W'(4700000), VALUE_W'(37400000)
    };
    localparam logic [SWITCH_W-1:0] SWITCH_ON_RESET = SWITCH_W'(360);

endpackage

`default_nettype wire

/* hw/rtl/resistance_to_switch_code.sv */
// Converts a requested resistance into a six-decade resistor switch code.
// A request passes eight register stages on its way to the output word: one
// input register, one stage that scales to milliohms and removes six switch
// on-resistances, then one stage per decade (largest first) that picks a digit
// 0..7 with seven parallel compares against precomputed multiples of the decade
// value and subtracts the chosen multiple. A new word is taken in every cycle
// while o_stall is low; stages move independently, so bubbles close up while a
// result waits at the output. Register writes update a table of decade
// multiples in the cycle after, still before the first decade stage reads it,
// so a request may be accepted at the same edge as a write; the user must make
// writes only while no request is in flight; the block does not enforce this.
`default_nettype none

module resistance_to_switch_code (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_valid,
    output      logic                               o_stall,
    input  wire logic [rsc_pkg::REQUEST_W-1:0]      i_request_ohm,
    // result channel
    output      logic                               o_valid,
    input  wire logic                               i_stall,
    output      logic [rsc_pkg::CODE_W-1:0]         o_switch_code,
    output      logic                               o_in_range,
    // register write port
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [rsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rsc_pkg::CFG_DAT_W-1:0]      i_cfg_wr_data
);

    // configuration registers
    logic [rsc_pkg::VALUE_W-1:0]  r_value [rsc_pkg::NUM_DECADES];
    logic [rsc_pkg::SWITCH_W-1:0] r_switch_on;

    // multiples 1..7 of each decade value
    logic [rsc_pkg::MULT_W-1:0]   r_mult [rsc_pkg::NUM_DECADES][1:rsc_pkg::DIGIT_MAX];

    // pipeline registers
    logic                         r_v     [rsc_pkg::NUM_STAGES];
    logic                         move    [rsc_pkg::NUM_STAGES];
    logic [rsc_pkg::REQUEST_W-1:0] r_req;
    logic [rsc_pkg::REM_W-1:0]    r_rem   [1:rsc_pkg::STAGE_LAST];
    logic [rsc_pkg::REM_W-1:0]    n_rem_first;
    logic [rsc_pkg::REM_W-1:0]    n_rem   [2:rsc_pkg::STAGE_LAST];
    logic [rsc_pkg::CODE_W-1:0]   r_code  [1:rsc_pkg::STAGE_LAST];
    logic [rsc_pkg::CODE_W-1:0]   n_code  [2:rsc_pkg::STAGE_LAST];
    logic                         r_range [1:rsc_pkg::STAGE_LAST];
    logic                         n_range;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rsc_pkg::NUM_DECADES; k++) begin
                r_value[k] <= rsc_pkg::VALUE_RESET[k];
            end
            r_switch_on <= rsc_pkg::SWITCH_ON_RESET;
        end else if (i_cfg_wr_en) begin
            for (int k = 0; k < rsc_pkg::NUM_DECADES; k++) begin
                if (i_cfg_index == rsc_pkg::CFG_IDX_W'(k)) begin
                    r_value[k] <= i_cfg_wr_data[rsc_pkg::VALUE_W-1:0];
                end
            end
            if (i_cfg_index == rsc_pkg::CFG_SWITCH_ON) begin
                r_switch_on <= i_cfg_wr_data[rsc_pkg::SWITCH_W-1:0];
            end
        end
    end

    // multiple table follows the decade values
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < rsc_pkg::NUM_DECADES; k++) begin
            for (int m = 1; m <= rsc_pkg::DIGIT_MAX; m++) begin
                r_mult[k][m] <= rsc_pkg::MULT_W'(m) * rsc_pkg::MULT_W'(r_value[k]);
            end
        end
    end

    // per-stage advance: a stage loads when empty or when the next one moves
    always_comb begin
        move[rsc_pkg::STAGE_LAST] = !r_v[rsc_pkg::STAGE_LAST] || !i_stall;
        for (int s = rsc_pkg::STAGE_LAST - 1; s >= 0; s--) begin
            move[s] = !r_v[s] || move[s+1];
        end
    end

    assign o_stall = !move[0];

    // offset stage: scale to milliohms and take off the switch resistance
    always_comb begin
        logic [rsc_pkg::REM_W-1:0]  target;
        logic [rsc_pkg::ACC0_W-1:0] acc0;
        target = rsc_pkg::REM_W'(r_req) * rsc_pkg::REM_W'(rsc_pkg::MILLI_PER_OHM);
        acc0   = rsc_pkg::ACC0_W'(r_switch_on) * rsc_pkg::ACC0_W'(rsc_pkg::SWITCHES_IN_PATH);
        if (target > rsc_pkg::REM_W'(acc0)) begin
            n_rem_first = target - rsc_pkg::REM_W'(acc0);
        end else begin
            n_rem_first = '0;
        end
        n_range   = (r_req >= rsc_pkg::REQUEST_W'(rsc_pkg::RANGE_LOW))
                 && (r_req <= rsc_pkg::REQUEST_W'(rsc_pkg::RANGE_HIGH));
    end

    // decade stages: largest decade first, remainder zero means done
    always_comb begin
        logic [rsc_pkg::DIGIT_W-1:0] dig;
        logic [rsc_pkg::MULT_W-1:0]  sub;
        int unsigned                 k;
        for (int s = 2; s <= rsc_pkg::STAGE_LAST; s++) begin
            k   = rsc_pkg::STAGE_LAST - s;
            dig = '0;
            sub = '0;
            if (r_rem[s-1] != '0) begin
                for (int m = 1; m <= rsc_pkg::DIGIT_MAX; m++) begin
                    if (r_rem[s-1] >= rsc_pkg::REM_W'(r_mult[k][m])) begin
                        dig = rsc_pkg::DIGIT_W'(m);
                        sub = r_mult[k][m];
                    end
                end
            end
            n_rem[s]  = r_rem[s-1] - rsc_pkg::REM_W'(sub);
            n_code[s] = r_code[s-1];
            n_code[s][rsc_pkg::DIGIT_W*k +: rsc_pkg::DIGIT_W] = dig;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < rsc_pkg::NUM_STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            if (move[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < rsc_pkg::NUM_STAGES; s++) begin
                if (move[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (move[0] && i_valid) begin
            r_req <= i_request_ohm;
        end
        if (move[1] && r_v[0]) begin
            r_rem[1]   <= n_rem_first;
            r_code[1]  <= '0;
            r_range[1] <= n_range;
        end
        for (int s = 2; s <= rsc_pkg::STAGE_LAST; s++) begin
            if (move[s] && r_v[s-1]) begin
                r_rem[s]   <= n_rem[s];
                r_code[s]  <= n_code[s];
                r_range[s] <= r_range[s-1];
            end
        end
    end

    // result word
    assign o_valid       = r_v[rsc_pkg::STAGE_LAST];
    assign o_switch_code = r_code[rsc_pkg::STAGE_LAST];
    assign o_in_range    = r_range[rsc_pkg::STAGE_LAST];

    // an accepted request always lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted request not held in input stage");

    // back-pressure only when the input stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v[0])
        else $error("input stalled with empty input stage");

    // a delivered result is not shown again without a new one behind it
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_v[rsc_pkg::STAGE_LAST-1]) |=> !o_valid)
        else $error("result word repeated");

endmodule

`default_nettype wire
